@@ hw/rtl/ipv6_address_text_parser_macros.svh @@
// ---------------------------------------------------------------------------
// IPv6 address text parser: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef IPV6_ADDRESS_TEXT_PARSER_MACROS_SVH
`define IPV6_ADDRESS_TEXT_PARSER_MACROS_SVH

// condition holds at every edge out of reset
`define IPV6TP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define IPV6TP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPV6TP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ipv6tp_pkg.sv @@
// ---------------------------------------------------------------------------
// IPv6 address text parser package
// Character codes, byte-store type and small arithmetic helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipv6tp_pkg;

  localparam int unsigned ADDR_BYTES = 16;

  // byte k of the address sits at index k
  typedef logic [ADDR_BYTES-1:0][7:0] bytes_t;

  localparam logic [4:0] BYTE_COUNT  = 5'd16;
  localparam logic [4:0] NO_PAD      = BYTE_COUNT;
  localparam logic [4:0] TAIL_LATEST = 5'd12;
  localparam logic [1:0] TAIL_OCTETS = 2'd3;
  localparam logic [7:0] PREFIX_BYTE = 8'hff;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] HEX_UC_OFS = 8'd55;  // 'A' - 10
  localparam logic [7:0] HEX_LC_OFS = 8'd87;  // 'a' - 10

  // v * 10 + d, modulo 256
  function automatic logic [7:0] mul10_add(logic [7:0] v, logic [3:0] d);
    logic [7:0] t;
    t = (v << 3) + (v << 1) + {4'b0000, d};
    return t;
  endfunction

  // write one byte if the index is still inside the address
  function automatic bytes_t put_byte(bytes_t s, logic [4:0] idx, logic [7:0] v);
    bytes_t t;
    t = s;
    if (idx < BYTE_COUNT) t[idx[3:0]] = v;
    return t;
  endfunction

endpackage

@@ hw/rtl/ipv6_address_text_parser.sv @@
// ---------------------------------------------------------------------------
// IPv6 address text parser
// Reads address text one character per transaction, gives the 128-bit
// address and an error flag on the last character.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel  in_valid/in_ready carries in_char_code (ASCII) and
//   in_last_char, which marks the final character of a string.
//   Output channel out_valid/out_ready carries out_addr_high (bytes 0..7),
//   out_addr_low (bytes 8..15) and out_parse_error; one transaction per
//   string, none for the other characters. On error the address is zero.
//   Throughput: one character per cycle, except that a last character
//   waits while the result register is still full. Each character passes
//   once through an input register, the parse and address-compaction
//   logic and, for a last character, the result register.
//   A stalled receiver holds the result; further characters of the next
//   string are still taken, and only a second last character waits until
//   the result register is free.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   parse state; the byte store is left as it is.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ipv6_address_text_parser_macros.svh"

module ipv6_address_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_addr_high,
  output logic [63:0] out_addr_low,
  output logic        out_parse_error
);

  // input register
  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_last_r;

  // parse state
  ipv6tp_pkg::bytes_t store_r, store_nxt;
  logic [4:0]  wi_r, wi_nxt;
  logic [4:0]  pad_r, pad_nxt;
  logic [15:0] chunk_r, chunk_nxt;
  logic        prev_colon_r, prev_colon_nxt;
  logic        at_start_r, at_start_nxt;
  logic        finished_r, finished_nxt;
  logic        err_r, err_nxt;
  logic [1:0]  octets_left_r, octets_left_nxt;
  logic        in_tail_r, in_tail_nxt;
  logic [7:0]  octet_r, octet_nxt;
  logic        digits_ended_r, digits_ended_nxt;

  // result register
  logic        out_valid_r;
  logic [63:0] out_high_r, out_high_nxt;
  logic [63:0] out_low_r, out_low_nxt;
  logic        out_err_r;

  logic        step_go;
  logic        is_dec, is_uc, is_lc, is_hex;
  logic [7:0]  dig_dec, dig_uc, dig_lc;
  logic [3:0]  hex_nib;
  logic        tail_ok;
  logic [7:0]  tail_v;
  logic [4:0]  fill_w, fill_n;
  logic        do_pad;
  ipv6tp_pkg::bytes_t res;

  // a last character needs the result register free
  assign step_go  = in_valid_r && (!in_last_r || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_go;

  assign is_dec = (in_char_r >= ipv6tp_pkg::CH_0)  && (in_char_r <= ipv6tp_pkg::CH_9);
  assign is_uc  = (in_char_r >= ipv6tp_pkg::CH_UA) && (in_char_r <= ipv6tp_pkg::CH_UF);
  assign is_lc  = (in_char_r >= ipv6tp_pkg::CH_LA) && (in_char_r <= ipv6tp_pkg::CH_LF);
  assign is_hex = is_dec || is_uc || is_lc;

  assign dig_dec = in_char_r - ipv6tp_pkg::CH_0;
  assign dig_uc  = in_char_r - ipv6tp_pkg::HEX_UC_OFS;
  assign dig_lc  = in_char_r - ipv6tp_pkg::HEX_LC_OFS;
  assign hex_nib = is_dec ? dig_dec[3:0] : (is_uc ? dig_uc[3:0] : dig_lc[3:0]);

  always_comb begin
    store_nxt        = store_r;
    wi_nxt           = wi_r;
    pad_nxt          = pad_r;
    chunk_nxt        = chunk_r;
    prev_colon_nxt   = prev_colon_r;
    at_start_nxt     = at_start_r;
    finished_nxt     = finished_r;
    err_nxt          = err_r;
    octets_left_nxt  = octets_left_r;
    in_tail_nxt      = in_tail_r;
    octet_nxt        = octet_r;
    digits_ended_nxt = digits_ended_r;
    tail_ok          = 1'b1;
    tail_v           = 8'd0;
    fill_w           = 5'd0;
    fill_n           = 5'd0;
    do_pad           = 1'b0;
    res              = '0;
    out_high_nxt     = '0;
    out_low_nxt      = '0;

    if (!finished_r) begin
      if (in_tail_r) begin
        if (!digits_ended_r && is_dec) begin
          octet_nxt = ipv6tp_pkg::mul10_add(octet_r, dig_dec[3:0]);
        end else if (in_char_r == ipv6tp_pkg::CH_DOT && octets_left_r > 2'd1) begin
          store_nxt        = ipv6tp_pkg::put_byte(store_nxt, wi_nxt, octet_r);
          wi_nxt           = wi_nxt + 5'd1;
          octets_left_nxt  = octets_left_r - 2'd1;
          octet_nxt        = 8'd0;
          digits_ended_nxt = 1'b0;
          if (in_last_r) begin
            err_nxt      = 1'b1;
            finished_nxt = 1'b1;
          end
        end else begin
          digits_ended_nxt = 1'b1;
        end
      end else if (in_char_r == ipv6tp_pkg::CH_COLON) begin
        if (at_start_r || prev_colon_r) begin
          if (pad_nxt != ipv6tp_pkg::NO_PAD && pad_nxt != wi_nxt) begin
            err_nxt      = 1'b1;
            finished_nxt = 1'b1;
          end else begin
            pad_nxt = wi_nxt;
          end
        end else begin
          store_nxt = ipv6tp_pkg::put_byte(store_nxt, wi_nxt, chunk_r[15:8]);
          wi_nxt    = wi_nxt + 5'd1;
          store_nxt = ipv6tp_pkg::put_byte(store_nxt, wi_nxt, chunk_r[7:0]);
          wi_nxt    = wi_nxt + 5'd1;
          chunk_nxt = 16'd0;
          if (wi_nxt >= ipv6tp_pkg::BYTE_COUNT) finished_nxt = 1'b1;
        end
        prev_colon_nxt = 1'b1;
        at_start_nxt   = 1'b0;
      end else if (is_hex) begin
        chunk_nxt      = {chunk_r[11:0], hex_nib};
        prev_colon_nxt = 1'b0;
        at_start_nxt   = 1'b0;
      end else if (in_char_r == ipv6tp_pkg::CH_DOT) begin
        // tail with nothing before it gets the ::ffff prefix
        if (wi_r == 5'd0) begin
          store_nxt[0] = ipv6tp_pkg::PREFIX_BYTE;
          store_nxt[1] = ipv6tp_pkg::PREFIX_BYTE;
          pad_nxt      = 5'd0;
          wi_nxt       = 5'd2;
        end else if (wi_r > ipv6tp_pkg::TAIL_LATEST) begin
          tail_ok      = 1'b0;
          err_nxt      = 1'b1;
          finished_nxt = 1'b1;
        end
        if (tail_ok) begin
          // first octet: the low three nibbles read as decimal digits
          tail_v    = ipv6tp_pkg::mul10_add(8'd0, chunk_r[11:8]);
          tail_v    = ipv6tp_pkg::mul10_add(tail_v, chunk_r[7:4]);
          tail_v    = ipv6tp_pkg::mul10_add(tail_v, chunk_r[3:0]);
          chunk_nxt = {chunk_r[3:0], 12'd0};
          store_nxt = ipv6tp_pkg::put_byte(store_nxt, wi_nxt, tail_v);
          wi_nxt    = wi_nxt + 5'd1;
          if (in_last_r) begin
            err_nxt      = 1'b1;
            finished_nxt = 1'b1;
          end else begin
            in_tail_nxt      = 1'b1;
            octets_left_nxt  = ipv6tp_pkg::TAIL_OCTETS;
            octet_nxt        = 8'd0;
            digits_ended_nxt = 1'b0;
          end
        end
      end else begin
        err_nxt      = 1'b1;
        finished_nxt = 1'b1;
      end
    end

    if (in_last_r) begin
      // end of string
      if (!finished_nxt) begin
        if (in_tail_nxt) begin
          if (octets_left_nxt > 2'd1) begin
            err_nxt = 1'b1;
          end else begin
            store_nxt = ipv6tp_pkg::put_byte(store_nxt, wi_nxt, octet_nxt);
            wi_nxt    = wi_nxt + 5'd1;
          end
        end else if (prev_colon_nxt) begin
          if (pad_nxt != ipv6tp_pkg::NO_PAD && pad_nxt != wi_nxt) begin
            err_nxt = 1'b1;
          end else begin
            pad_nxt = wi_nxt;
          end
        end else begin
          store_nxt = ipv6tp_pkg::put_byte(store_nxt, wi_nxt, chunk_nxt[15:8]);
          wi_nxt    = wi_nxt + 5'd1;
          store_nxt = ipv6tp_pkg::put_byte(store_nxt, wi_nxt, chunk_nxt[7:0]);
          wi_nxt    = wi_nxt + 5'd1;
          if (wi_nxt < ipv6tp_pkg::BYTE_COUNT && pad_nxt == ipv6tp_pkg::NO_PAD) begin
            err_nxt = 1'b1;
          end
        end
      end

      // open the zero run at the marker: bytes from it move to the top
      fill_w = (wi_nxt > ipv6tp_pkg::BYTE_COUNT) ? ipv6tp_pkg::BYTE_COUNT : wi_nxt;
      fill_n = ipv6tp_pkg::BYTE_COUNT - fill_w;
      do_pad = (pad_nxt < ipv6tp_pkg::NO_PAD) && (pad_nxt <= fill_w);
      if (!err_nxt) begin
        for (int k = 0; k < ipv6tp_pkg::ADDR_BYTES; k++) begin
          if (!do_pad || 5'(k) < pad_nxt) begin
            res[k] = store_nxt[k];
          end else if (5'(k) < pad_nxt + fill_n) begin
            res[k] = 8'd0;
          end else begin
            res[k] = store_nxt[4'(k) - fill_n[3:0]];
          end
        end
      end
      for (int k = 0; k < ipv6tp_pkg::ADDR_BYTES / 2; k++) begin
        out_high_nxt[63 - 8*k -: 8] = res[k];
        out_low_nxt[63 - 8*k -: 8]  = res[k + ipv6tp_pkg::ADDR_BYTES / 2];
      end
      store_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      wi_r           <= 5'd0;
      pad_r          <= ipv6tp_pkg::NO_PAD;
      chunk_r        <= 16'd0;
      prev_colon_r   <= 1'b0;
      at_start_r     <= 1'b1;
      finished_r     <= 1'b0;
      err_r          <= 1'b0;
      octets_left_r  <= 2'd0;
      in_tail_r      <= 1'b0;
      octet_r        <= 8'd0;
      digits_ended_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (step_go && in_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (step_go) begin
        if (in_last_r) begin
          wi_r           <= 5'd0;
          pad_r          <= ipv6tp_pkg::NO_PAD;
          chunk_r        <= 16'd0;
          prev_colon_r   <= 1'b0;
          at_start_r     <= 1'b1;
          finished_r     <= 1'b0;
          err_r          <= 1'b0;
          octets_left_r  <= 2'd0;
          in_tail_r      <= 1'b0;
          octet_r        <= 8'd0;
          digits_ended_r <= 1'b0;
        end else begin
          wi_r           <= wi_nxt;
          pad_r          <= pad_nxt;
          chunk_r        <= chunk_nxt;
          prev_colon_r   <= prev_colon_nxt;
          at_start_r     <= at_start_nxt;
          finished_r     <= finished_nxt;
          err_r          <= err_nxt;
          octets_left_r  <= octets_left_nxt;
          in_tail_r      <= in_tail_nxt;
          octet_r        <= octet_nxt;
          digits_ended_r <= digits_ended_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_code;
      in_last_r <= in_last_char;
    end
    if (step_go) store_r <= store_nxt;
    if (step_go && in_last_r) begin
      out_high_r <= out_high_nxt;
      out_low_r  <= out_low_nxt;
      out_err_r  <= err_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_addr_high   = out_high_r;
  assign out_addr_low    = out_low_r;
  assign out_parse_error = out_err_r;

  `IPV6TP_ASSERT_ALWAYS(a_wi_range, wi_r <= ipv6tp_pkg::BYTE_COUNT, "write index past end")
  `IPV6TP_ASSERT_IMP(a_err_zero, out_valid_r && out_err_r, out_high_r == 64'd0 && out_low_r == 64'd0, "error result not zero")
  `IPV6TP_ASSERT_NEXT(a_clear_after_last, step_go && in_last_r, wi_r == 5'd0 && at_start_r && !finished_r && !err_r, "parse state not cleared after string")
  `IPV6TP_ASSERT_IMP(a_out_from_last, $rose(out_valid_r), $past(step_go && in_last_r), "result without last character")
  `IPV6TP_ASSERT_IMP(a_tail_has_bytes, in_tail_r, wi_r >= 5'd1 && octets_left_r != 2'd0, "dotted tail without bytes")

endmodule

@@ test/ipv6_address_text_parser_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IPv6 address text parser testbench
// Feeds address strings one character per transaction, with directed corner
// strings first and then random well-formed, damaged and noise strings. An
// in-bench parser predicts each 128-bit address and error flag, and every
// output transaction is checked against the oldest prediction. Both sides
// idle at random.
// ---------------------------------------------------------------------------

module ipv6_address_text_parser_tb;

  localparam int unsigned TOTAL_CHARS  = 1450;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct {
    logic [7:0]  code;
    logic        last;
    int unsigned gap;
    bit          hold;
  } char_item_t;

  typedef struct {
    logic [63:0] high;
    logic [63:0] low;
    logic        error;
  } addr_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_code = 8'h00;
  logic        in_last_char = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_addr_high;
  logic [63:0] out_addr_low;
  logic        out_parse_error;

  char_item_t   char_queue[$];
  addr_result_t expected_addrs[$];
  logic [7:0]   text_buf[$];

  // predictor state
  ipv6tp_pkg::bytes_t addr_bytes;
  logic [4:0] wr_idx;
  logic [4:0] pad_idx;
  logic [15:0] chunk;
  logic       prev_colon;
  logic       at_start;
  logic       finished;
  logic       err_seen;
  logic [1:0] oct_left;
  logic       in_tail;
  logic [7:0] oct_val;
  logic       dig_end;

  int unsigned gap_left;
  int unsigned rx_wait;
  int unsigned rx_draw;
  int unsigned fail_count;
  int unsigned string_total;
  int unsigned hold_total;
  int unsigned chars_taken;
  int unsigned results_checked;
  int unsigned errors_flagged;
  int unsigned cycle_count;

  string hex_set   = "0123456789abcdefABCDEF";
  string punct_set = ":.gG /-";
  string noise_set = "0123456789abcdef:.x";

  ipv6_address_text_parser DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .in_last_char    (in_last_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_addr_high   (out_addr_high),
    .out_addr_low    (out_addr_low),
    .out_parse_error (out_parse_error)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------- address prediction ----------------

  task automatic clear_parse();
    wr_idx     = 5'd0;
    pad_idx    = ipv6tp_pkg::NO_PAD;
    chunk      = 16'h0000;
    prev_colon = 1'b0;
    at_start   = 1'b1;
    finished   = 1'b0;
    err_seen   = 1'b0;
    oct_left   = 2'd0;
    in_tail    = 1'b0;
    oct_val    = 8'h00;
    dig_end    = 1'b0;
  endtask

  task automatic abort_parse();
    err_seen = 1'b1;
    finished = 1'b1;
  endtask

  task automatic store_octet(input logic [7:0] v);
    if (wr_idx < ipv6tp_pkg::BYTE_COUNT) addr_bytes[wr_idx[3:0]] = v;
    wr_idx = wr_idx + 5'd1;
  endtask

  task automatic save_group();
    store_octet(chunk[15:8]);
    store_octet(chunk[7:0]);
    chunk = 16'h0000;
  endtask

  task automatic note_zero_run();
    if (pad_idx != ipv6tp_pkg::NO_PAD && pad_idx != wr_idx) abort_parse();
    else pad_idx = wr_idx;
  endtask

  task automatic begin_tail(input logic last);
    logic [7:0] v;
    v = 8'h00;
    if (wr_idx == 5'd0) begin
      addr_bytes[0] = ipv6tp_pkg::PREFIX_BYTE;
      addr_bytes[1] = ipv6tp_pkg::PREFIX_BYTE;
      pad_idx = 5'd0;
      wr_idx = 5'd2;
    end else if (wr_idx > ipv6tp_pkg::TAIL_LATEST) begin
      abort_parse();
      return;
    end
    // low three nibbles of the group, read as decimal digits
    repeat (3) begin
      v = v * 8'd10 + {4'd0, chunk[11:8]};
      chunk = chunk << 4;
    end
    store_octet(v);
    if (last) begin
      abort_parse();
      return;
    end
    in_tail = 1'b1;
    oct_left = ipv6tp_pkg::TAIL_OCTETS;
    oct_val = 8'h00;
    dig_end = 1'b0;
  endtask

  task automatic hex_step(input logic [7:0] c, input logic last);
    logic [3:0] d;
    if (c == ipv6tp_pkg::CH_COLON) begin
      if (at_start || prev_colon) begin
        note_zero_run();
      end else begin
        save_group();
        if (wr_idx >= ipv6tp_pkg::BYTE_COUNT) finished = 1'b1;
      end
      prev_colon = 1'b1;
      at_start = 1'b0;
      return;
    end
    if (c >= ipv6tp_pkg::CH_0 && c <= ipv6tp_pkg::CH_9) begin
      d = 4'(c - ipv6tp_pkg::CH_0);
    end else if (c >= ipv6tp_pkg::CH_UA && c <= ipv6tp_pkg::CH_UF) begin
      d = 4'(c - ipv6tp_pkg::HEX_UC_OFS);
    end else if (c >= ipv6tp_pkg::CH_LA && c <= ipv6tp_pkg::CH_LF) begin
      d = 4'(c - ipv6tp_pkg::HEX_LC_OFS);
    end else if (c == ipv6tp_pkg::CH_DOT) begin
      begin_tail(last);
      return;
    end else begin
      abort_parse();
      return;
    end
    chunk = {chunk[11:0], d};
    prev_colon = 1'b0;
    at_start = 1'b0;
  endtask

  task automatic tail_step(input logic [7:0] c, input logic last);
    if (!dig_end && c >= ipv6tp_pkg::CH_0 && c <= ipv6tp_pkg::CH_9) begin
      oct_val = oct_val * 8'd10 + (c - ipv6tp_pkg::CH_0);
    end else if (c == ipv6tp_pkg::CH_DOT && oct_left > 2'd1) begin
      store_octet(oct_val);
      oct_left = oct_left - 2'd1;
      oct_val = 8'h00;
      dig_end = 1'b0;
      if (last) abort_parse();
    end else begin
      dig_end = 1'b1;
    end
  endtask

  task automatic close_string();
    if (in_tail) begin
      if (oct_left > 2'd1) begin
        abort_parse();
        return;
      end
      store_octet(oct_val);
    end else if (prev_colon) begin
      note_zero_run();
    end else begin
      save_group();
      if (wr_idx < ipv6tp_pkg::BYTE_COUNT && pad_idx == ipv6tp_pkg::NO_PAD) begin
        abort_parse();
        return;
      end
    end
    finished = 1'b1;
  endtask

  task automatic emit_address();
    ipv6tp_pkg::bytes_t res;
    logic [4:0]   w;
    logic [4:0]   n;
    int           k;
    addr_result_t r;
    res = '0;
    if (!err_seen) begin
      res = addr_bytes;
      w = (wr_idx > ipv6tp_pkg::BYTE_COUNT) ? ipv6tp_pkg::BYTE_COUNT : wr_idx;
      // open the zero run at the marker, shifting the later groups up
      if (pad_idx < ipv6tp_pkg::NO_PAD && pad_idx <= w && w < ipv6tp_pkg::BYTE_COUNT) begin
        n = ipv6tp_pkg::BYTE_COUNT - w;
        for (k = 15; k >= int'(pad_idx) + int'(n); k--) res[k] = addr_bytes[k - int'(n)];
        for (k = int'(pad_idx); k < int'(pad_idx) + int'(n); k++) res[k] = 8'h00;
      end
    end
    addr_bytes = res;
    r.high = '0;
    r.low  = '0;
    for (k = 0; k < 8; k++) begin
      r.high = {r.high[55:0], res[k]};
      r.low  = {r.low[55:0], res[k + 8]};
    end
    r.error = err_seen;
    expected_addrs.push_back(r);
    clear_parse();
  endtask

  task automatic parse_char(input logic [7:0] c, input logic last);
    if (!finished) begin
      if (in_tail) tail_step(c, last);
      else hex_step(c, last);
    end
    if (last) begin
      if (!finished) close_string();
      emit_address();
    end
  endtask

  // ---------------- string building ----------------

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void commit_text(bit hold);
    char_item_t it;
    int         i;
    for (i = 0; i < text_buf.size(); i++) begin
      it.code = text_buf[i];
      it.last = (i == text_buf.size() - 1);
      it.gap  = (string_total % 8 == 7) ? 0 : $urandom_range(0, 5);
      it.hold = hold && (i == 0);
      char_queue.push_back(it);
    end
    if (hold) hold_total++;
    string_total++;
    text_buf.delete();
  endfunction

  function automatic void add_group();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    repeat (n) text_buf.push_back(hex_set[$urandom_range(0, 21)]);
  endfunction

  function automatic void add_groups(int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i != 0) text_buf.push_back(ipv6tp_pkg::CH_COLON);
      add_group();
    end
  endfunction

  function automatic void add_quad();
    int i;
    int v;
    for (i = 0; i < 4; i++) begin
      if (i != 0) text_buf.push_back(ipv6tp_pkg::CH_DOT);
      v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9999) : $urandom_range(0, 255);
      add_text($sformatf("%0d", v));
    end
  endfunction

  function automatic void build_wellformed();
    int left;
    int right;
    case ($urandom_range(0, 2))
      0: add_groups(8);
      1: begin
        left = $urandom_range(0, 7);
        right = $urandom_range(0, 7 - left);
        add_groups(left);
        add_text("::");
        add_groups(right);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: ;  // bare dotted quad
          1: begin
            add_groups($urandom_range(1, 6));
            text_buf.push_back(ipv6tp_pkg::CH_COLON);
          end
          2: begin
            add_text("::");
            right = $urandom_range(0, 5);
            if (right != 0) begin
              add_groups(right);
              text_buf.push_back(ipv6tp_pkg::CH_COLON);
            end
          end
          default: begin
            add_groups($urandom_range(1, 3));
            add_text("::");
            right = $urandom_range(0, 2);
            if (right != 0) begin
              add_groups(right);
              text_buf.push_back(ipv6tp_pkg::CH_COLON);
            end
          end
        endcase
        add_quad();
      end
    endcase
  endfunction

  function automatic void damage_text();
    int pos;
    int keep;
    pos = $urandom_range(0, text_buf.size() - 1);
    case ($urandom_range(0, 3))
      0: text_buf[pos] = 8'($urandom_range(0, 255));
      1: text_buf.insert(pos, punct_set[$urandom_range(0, punct_set.len() - 1)]);
      2: begin
        keep = $urandom_range(1, text_buf.size());
        while (text_buf.size() > keep) void'(text_buf.pop_back());
      end
      default: repeat ($urandom_range(1, 4))
        text_buf.push_back(noise_set[$urandom_range(0, noise_set.len() - 1)]);
    endcase
  endfunction

  function automatic void build_random_string();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      build_wellformed();
    end else if (kind < 90) begin
      build_wellformed();
      damage_text();
    end else begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 1) != 0) text_buf.push_back(8'($urandom_range(0, 255)));
        else text_buf.push_back(noise_set[$urandom_range(0, noise_set.len() - 1)]);
      end
    end
    commit_text($urandom_range(0, 24) == 0);
  endfunction

  task automatic add_directed(string s, bit hold);
    add_text(s);
    commit_text(hold);
  endtask

  // ---------------- mismatch reporting ----------------

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s at result %0d: got %h, want %h", what, results_checked, got, want);
    fail_count++;
  endtask

  // ---------------- sender ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (char_queue.size() != 0 &&
                   (!char_queue[0].hold || (!in_valid && expected_addrs.size() == 0))) begin
        in_valid     <= 1'b1;
        in_char_code <= char_queue[0].code;
        in_last_char <= char_queue[0].last;
        gap_left     <= char_queue[0].gap;
        void'(char_queue.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor and receiver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_addrs.size() == 0) begin
          report_mismatch("unexpected transaction", out_addr_high, 64'h0);
        end else begin
          if (out_addr_high !== expected_addrs[0].high)
            report_mismatch("addr_high", out_addr_high, expected_addrs[0].high);
          if (out_addr_low !== expected_addrs[0].low)
            report_mismatch("addr_low", out_addr_low, expected_addrs[0].low);
          if (out_parse_error !== expected_addrs[0].error)
            report_mismatch("parse_error", {63'd0, out_parse_error},
                            {63'd0, expected_addrs[0].error});
          if (expected_addrs[0].error) errors_flagged++;
          void'(expected_addrs.pop_front());
        end
        results_checked++;
        // every fourth stretch of ten results runs without stalls
        rx_draw = ((results_checked % 40) >= 30) ? 0 : $urandom_range(0, 5);
        rx_wait <= rx_draw;
        out_ready <= (rx_draw == 0);
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        out_ready <= (rx_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
      if (in_valid && in_ready) begin
        parse_char(in_char_code, in_last_char);
        chars_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_addrs.size());
      $display("ipv6_address_text_parser_tb failed");
      $finish;
    end
  end

  // ---------------- stimulus and end of run ----------------

  initial begin
    addr_bytes = '0;
    clear_parse();

    // a full address first, so the byte store is defined before any short tail
    add_directed("1:2:3:4:5:6:7:8", 1'b0);
    add_directed("FFFF:ffff:ABCD:abcd:0:00:000:0000", 1'b0);
    add_directed("12345:6:7:8:9:a:b:c", 1'b0);
    add_directed("::", 1'b0);
    add_directed("::1", 1'b0);
    add_directed("fe80::", 1'b0);
    add_directed("1::2", 1'b0);
    add_directed(":1:2:3:4:5:6:7", 1'b0);
    add_directed("1:2:3:4:5:6:7:8:9:zz", 1'b0);
    add_directed("1:2:3", 1'b0);
    add_directed("1::2::3", 1'b0);
    add_directed("1:2:3:", 1'b0);
    add_directed("1:2:g:3", 1'b0);
    add_directed("1.2.3.4", 1'b1);
    add_directed("::ffff:192.168.1.255", 1'b0);
    add_directed("1:2:3:4:5:6:7.8.9.10", 1'b0);
    add_directed("1:2:3:4:5:6:7:8.1.2.3", 1'b0);
    add_directed("1.2.3", 1'b0);
    add_directed("1.2.", 1'b0);
    add_directed("5.", 1'b0);
    add_directed("1.2x.999.4abc", 1'b0);
    add_directed("1:2:3.4.5.6", 1'b0);
    add_directed("1:2::3.4.5.6", 1'b0);
    add_directed("x", 1'b0);
    add_directed("a:b:c:d:e:f:1:2:", 1'b0);

    while (char_queue.size() < TOTAL_CHARS) build_random_string();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (char_queue.size() != 0 || in_valid || expected_addrs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d strings (%0d characters), %0d with the sender held for a drain",
             string_total, chars_taken, hold_total);
    $display("%0d addresses checked, %0d flagged malformed, %0d mismatches",
             results_checked, errors_flagged, fail_count);
    if (fail_count == 0) begin
      $display("ipv6_address_text_parser_tb passed");
    end else begin
      $display("ipv6_address_text_parser_tb failed");
    end
    $finish;
  end

endmodule
